// ===== hw/rtl/mpfb_pkg.sv =====
// Package for the monochrome page framebuffer draw engine.
// Holds command codes, pixel operation codes, and the sequencer state type.
package mpfb_pkg;

  // Command codes of the input request.
  localparam logic [2:0] OP_PIXEL = 3'd0;
  localparam logic [2:0] OP_LINE  = 3'd1;
  localparam logic [2:0] OP_RECT  = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [2:0] MODE_RESET = 3'd3;

  typedef enum logic [1:0] {
    PIX_NONE,
    PIX_SET,
    PIX_CLEAR,
    PIX_FLIP
  } pix_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINE,
    ST_RECT,
    ST_CLEAR,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } state_t;

  // Pixel operation selected by the draw mode.
  function automatic pix_op_t mode_to_op(input logic [2:0] mode);
    pix_op_t r;
    unique case (mode)
      3'd0: r = PIX_FLIP;
      3'd2, 3'd3: r = PIX_SET;
      3'd5, 3'd7: r = PIX_CLEAR;
      default: r = PIX_NONE;
    endcase
    return r;
  endfunction

  // Apply an operation to the bits of a byte selected by a mask.
  function automatic logic [7:0] apply_op(input pix_op_t op, input logic [7:0] d,
                                          input logic [7:0] m);
    logic [7:0] r;
    unique case (op)
      PIX_SET:   r = d | m;
      PIX_CLEAR: r = d & ~m;
      PIX_FLIP:  r = d ^ m;
      default:   r = d;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/mpfb_if.sv =====
// Valid/ready channel interfaces for the framebuffer draw engine.
// Depends on nothing; payload fields follow the request and result items.
interface mpfb_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] extent_x;
  logic signed [15:0] extent_y;
  modport source (output valid, operation, pos_x, pos_y, extent_x, extent_y, input ready);
  modport sink   (input valid, operation, pos_x, pos_y, extent_x, extent_y, output ready);
endinterface

interface mpfb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

interface mpfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] draw_mode;
  modport source (output valid, draw_mode, input ready);
  modport sink   (input valid, draw_mode, output ready);
endinterface

// ===== hw/rtl/mpfb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module mpfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 896
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== hw/rtl/mono_page_framebuffer_draw.sv =====
// Top level of the monochrome page framebuffer draw engine.
// Uses mpfb_pkg, the channel interfaces and mpfb_ram.
// Pixels and lines run through the line stepper; a read of an off-screen point, an unused
// code or an empty rectangle goes straight to the result; clear writes every byte without a read.
// Other bytes are a RAM read then a write; the next request is taken while the result waits,
// and a result that is not taken holds the sequencer in its last cycle. Reset: idle, mode 3.
module mono_page_framebuffer_draw
  import mpfb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 112,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  mpfb_cmd_if.sink   in_cmd,
  mpfb_res_if.source out_res,
  mpfb_cfg_if.sink   cfg_wr
);
  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int DEPTH = PAGES * SCREEN_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  logic [2:0] mode_r;
  state_t     state_r, state_nxt, ret_r, ret_nxt;

  // Working coordinates, wide enough for line steps beyond 16 bits.
  logic signed [17:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [17:0] xe_r, xe_nxt, ye_r, ye_nxt, x0_r, x0_nxt;
  logic signed [18:0] d_r, d_nxt, ikeep_r, ikeep_nxt, istep_r, istep_nxt;
  logic signed [1:0]  ax_r, ax_nxt, ay_r, ay_nxt, bx_r, bx_nxt, by_r, by_nxt;
  logic [16:0]        n_r, n_nxt;
  logic [7:0]         mask_r, mask_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic               rd_r, rd_nxt;
  logic [7:0]         res_r, res_nxt;
  logic [7:0]         out_r, out_nxt;
  logic               ovalid_r, ovalid_nxt;

  logic               we;
  logic [7:0]         wdata, rdata;
  logic [AW-1:0]      raddr;
  pix_op_t            pop;

  // Line setup terms.
  logic signed [17:0] sx1, sy1, sx2, sy2, ldx, ldy;

  assign pop = mode_to_op(mode_r);
  assign sx1 = 18'(in_cmd.pos_x);
  assign sy1 = 18'(in_cmd.pos_y);
  assign sx2 = 18'(in_cmd.extent_x);
  assign sy2 = 18'(in_cmd.extent_y);
  assign ldx = (sx2 > sx1) ? sx2 - sx1 : sx1 - sx2;
  assign ldy = (sy2 > sy1) ? sy2 - sy1 : sy1 - sy2;

  assign in_cmd.ready    = (state_r == ST_IDLE);
  assign out_res.valid   = ovalid_r;
  assign out_res.read_data = out_r;
  assign cfg_wr.ready    = 1'b1;

  // Byte address of pixel (x, y); only used for on-screen points.
  function automatic logic [AW-1:0] pix_addr(input logic signed [17:0] x,
                                             input logic signed [17:0] y);
    logic [AW:0] a;
    a = (AW+1)'(y[17:3]) * (AW+1)'(SCREEN_WIDTH) + (AW+1)'(x);
    return a[AW-1:0];
  endfunction

  function automatic logic on_screen(input logic signed [17:0] x,
                                     input logic signed [17:0] y);
    return x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT;
  endfunction

  mpfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .wr_en(we), .wr_addr(addr_r), .wr_data(wdata),
    .rd_addr(raddr), .rd_data(rdata)
  );

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ret_r    <= ST_IDLE;
      mode_r   <= MODE_RESET;
      ovalid_r <= 1'b0;
      rd_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      ovalid_r <= ovalid_nxt;
      rd_r     <= rd_nxt;
      if (cfg_wr.valid) begin
        mode_r <= cfg_wr.draw_mode;
      end
    end
    x_r <= x_nxt; y_r <= y_nxt; xe_r <= xe_nxt; ye_r <= ye_nxt; x0_r <= x0_nxt;
    d_r <= d_nxt; ikeep_r <= ikeep_nxt; istep_r <= istep_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt; bx_r <= bx_nxt; by_r <= by_nxt;
    n_r <= n_nxt; mask_r <= mask_nxt; addr_r <= addr_nxt; res_r <= res_nxt;
    out_r <= out_nxt;
  end

  // Next state: each byte touch of a pixel, line or rectangle goes through ST_WRITE after its read.
  always_comb begin
    logic signed [17:0] yt, yb;
    logic [7:0]         m;
    state_nxt = state_r; ret_nxt = ret_r;
    x_nxt = x_r; y_nxt = y_r; xe_nxt = xe_r; ye_nxt = ye_r; x0_nxt = x0_r;
    d_nxt = d_r; ikeep_nxt = ikeep_r; istep_nxt = istep_r;
    ax_nxt = ax_r; ay_nxt = ay_r; bx_nxt = bx_r; by_nxt = by_r;
    n_nxt = n_r; mask_nxt = mask_r; addr_nxt = addr_r; res_nxt = res_r;
    out_nxt = out_r;
    ovalid_nxt = ovalid_r && !out_res.ready;
    rd_nxt = 1'b0;
    raddr = addr_r;
    we = 1'b0;
    wdata = apply_op(pop, rdata, mask_r);
    yt = '0; yb = '0; m = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_cmd.valid) begin
          res_nxt = '0;
          unique case (in_cmd.operation)
            OP_PIXEL: begin
              x_nxt = sx1; y_nxt = sy1; n_nxt = '0;
              ax_nxt = '0; ay_nxt = '0; bx_nxt = '0; by_nxt = '0;
              d_nxt = '0; ikeep_nxt = '0; istep_nxt = '0;
              state_nxt = ST_LINE;
            end
            OP_LINE: begin
              x_nxt = sx1; y_nxt = sy1;
              bx_nxt = (sx1 > sx2) ? -2'sd1 : 2'sd1;
              by_nxt = (sy1 > sy2) ? -2'sd1 : 2'sd1;
              if (ldx >= ldy) begin
                n_nxt = ldx[16:0];
                d_nxt = 19'(2 * ldy) - 19'(ldx);
                ikeep_nxt = 19'(2 * ldy);
                istep_nxt = 19'(2 * (ldy - ldx));
                ax_nxt = (sx1 > sx2) ? -2'sd1 : 2'sd1; ay_nxt = '0;
              end else begin
                n_nxt = ldy[16:0];
                d_nxt = 19'(2 * ldx) - 19'(ldy);
                ikeep_nxt = 19'(2 * ldx);
                istep_nxt = 19'(2 * (ldx - ldy));
                ax_nxt = '0; ay_nxt = (sy1 > sy2) ? -2'sd1 : 2'sd1;
              end
              state_nxt = ST_LINE;
            end
            OP_RECT: begin
              if (in_cmd.extent_x <= 0 || in_cmd.extent_y <= 0) begin
                state_nxt = ST_DONE;
              end else begin
                x0_nxt = (sx1 < 0) ? '0 : sx1;
                x_nxt  = (sx1 < 0) ? '0 : sx1;
                y_nxt  = (sy1 < 0) ? '0 : sy1;
                xe_nxt = (sx1 + sx2 > SCREEN_WIDTH) ? 18'(SCREEN_WIDTH) : sx1 + sx2;
                ye_nxt = (sy1 + sy2 > SCREEN_HEIGHT) ? 18'(SCREEN_HEIGHT) : sy1 + sy2;
                state_nxt = ST_RECT;
              end
            end
            OP_CLEAR: begin
              addr_nxt = '0;
              state_nxt = ST_CLEAR;
            end
            OP_READ: begin
              if (on_screen(sx1, sy1)) begin
                addr_nxt = pix_addr(sx1, sy1);
                state_nxt = ST_READ;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_LINE: begin
        // Plot current point (if visible), then step or finish.
        if (on_screen(x_r, y_r)) begin
          addr_nxt = pix_addr(x_r, y_r);
          raddr = pix_addr(x_r, y_r);
          mask_nxt = 8'(1) << y_r[2:0];
          rd_nxt = 1'b1;
          ret_nxt = (n_r == 0) ? ST_DONE : ST_LINE;
          state_nxt = ST_WRITE;
        end else if (n_r == 0) begin
          state_nxt = ST_DONE;
        end
        if (d_r < 0) begin
          d_nxt = d_r + ikeep_r; x_nxt = x_r + 18'(ax_r); y_nxt = y_r + 18'(ay_r);
        end else begin
          d_nxt = d_r + istep_r; x_nxt = x_r + 18'(bx_r); y_nxt = y_r + 18'(by_r);
        end
        n_nxt = n_r - 17'd1;
      end
      ST_RECT: begin
        // One byte column of the current page band per visit.
        if (x_r >= xe_r || y_r >= ye_r) begin
          state_nxt = ST_DONE;
        end else begin
          yt = y_r;
          yb = {y_r[17:3], 3'b111};
          if (yb >= ye_r) yb = ye_r - 18'sd1;
          m = (8'hFF << yt[2:0]) & (8'hFF >> (3'd7 - yb[2:0]));
          mask_nxt = m;
          addr_nxt = pix_addr(x_r, y_r);
          raddr = pix_addr(x_r, y_r);
          rd_nxt = 1'b1;
          ret_nxt = ST_RECT;
          state_nxt = ST_WRITE;
          if (x_r + 18'sd1 >= xe_r) begin
            x_nxt = x0_r;
            y_nxt = {y_r[17:3], 3'b000} + 18'sd8;
          end else begin
            x_nxt = x_r + 18'sd1;
          end
        end
      end
      ST_CLEAR: begin
        we = 1'b1;
        wdata = mode_r[2] ? 8'hFF : 8'h00;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == AW'(DEPTH - 1)) state_nxt = ST_DONE;
      end
      ST_READ: begin
        if (!rd_r) begin
          rd_nxt = 1'b1;
        end else begin
          res_nxt = rdata;
          state_nxt = ST_DONE;
        end
      end
      ST_WRITE: begin
        // rdata is valid here: modify and write back. No overlap, one at a time.
        we = 1'b1;
        state_nxt = ret_r;
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free or being emptied.
        if (!ovalid_r || out_res.ready) begin
          ovalid_nxt = 1'b1;
          out_nxt = res_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // A waiting result stays offered and unchanged until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
                   ovalid_r && !out_res.ready |=> ovalid_r && $stable(out_r))
    else $error("waiting result dropped or changed");
  // A write-back always follows a read issued in the cycle before.
  assert property (@(posedge clk) disable iff (!rst_n) state_r == ST_WRITE |-> $past(rd_nxt))
    else $error("write-back without prior read");
  // The sequencer holds its last cycle while a result waits.
  assert property (@(posedge clk) disable iff (!rst_n)
                   state_r == ST_DONE && ovalid_r && !out_res.ready |=> state_r == ST_DONE)
    else $error("result overwritten while waiting");
endmodule
